FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ERG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ERG_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ERG_ASSERT(lbl, clk, rst, prop, msg)
`define ERG_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

FILE: sv/erg_pkg.sv
// Shared types and constants of the euclidean rhythm generator.
package erg_pkg;

  localparam int MAX_STEPS = 64;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MERGE,
    S_FLAT,
    S_ROT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic merge;
    logic flat;
    logic rotate;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic merge_done;
    logic flat_done;
  } status_t;

endpackage

FILE: sv/erg_dp.sv
// Datapath: group registers, merge step, flatten step, rotator and output register.
module erg_dp import erg_pkg::*; (
  input  logic               clk,
  input  logic [7:0]         hits,
  input  logic [7:0]         steps,
  input  logic [7:0]         rotation,
  input  cmd_t               cmd,
  output status_t            status,
  output logic [PAT_W-1:0]   pattern,
  output logic [LEN_W-1:0]   length,
  output logic               too_long
);

  logic [7:0]       steps_r;
  logic [7:0]       rot_r;
  logic [LEN_W-1:0] a;
  logic [LEN_W-1:0] b;
  logic [LEN_W-1:0] lx;
  logic [LEN_W-1:0] ly;
  logic [LEN_W-1:0] pos;
  logic [PAT_W-1:0] x;
  logic [PAT_W-1:0] y;
  logic [PAT_W-1:0] pat;
  logic             triv;
  logic             tl;

  logic             in_too;
  logic [PAT_W-1:0] x_cat;
  logic [LEN_W-1:0] l_sum;
  logic [LEN_W-1:0] back;
  logic [PAT_W-1:0] mask;
  logic             do_rot;

  function automatic logic [PAT_W-1:0] low_mask(input logic [LEN_W-1:0] n);
    logic [PAT_W-1:0] m;
    if (n[LEN_W-1]) begin
      m = '1;
    end else begin
      m = (PAT_W'(1) << n[LEN_W-2:0]) - PAT_W'(1);
    end
    return m;
  endfunction

  assign in_too = steps > 8'(MAX_STEPS);
  // front group gets one remainder group appended
  assign x_cat  = x | (y << lx[LEN_W-2:0]);
  assign l_sum  = lx + ly;
  assign back   = steps_r[LEN_W-1:0] - {1'b0, rot_r[LEN_W-2:0]};
  assign mask   = low_mask(steps_r[LEN_W-1:0]);
  assign do_rot = (rot_r != 8'd0) && (rot_r < steps_r);

  assign status.trivial    = triv;
  assign status.merge_done = b <= LEN_W'(1);
  assign status.flat_done  = (a == '0) && (b == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      steps_r <= steps;
      rot_r   <= rotation;
      a       <= hits[LEN_W-1:0];
      b       <= steps[LEN_W-1:0] - hits[LEN_W-1:0];
      x       <= PAT_W'(1);
      y       <= '0;
      lx      <= LEN_W'(1);
      ly      <= LEN_W'(1);
      pos     <= '0;
      tl      <= in_too;
      triv    <= (steps == 8'd0) || in_too || (hits == 8'd0) || (hits >= steps);
      if (!in_too && (steps != 8'd0) && (hits >= steps)) begin
        pat <= low_mask(steps[LEN_W-1:0]);
      end else begin
        pat <= '0;
      end
    end
    if (cmd.merge) begin
      x  <= x_cat;
      lx <= l_sum;
      if (a > b) begin
        // leftover front groups become the new remainder
        y  <= x;
        ly <= lx;
        a  <= b;
        b  <= a - b;
      end else begin
        b <= b - a;
      end
    end
    if (cmd.flat) begin
      if (a != '0) begin
        pat <= pat | (x << pos[LEN_W-2:0]);
        pos <= pos + lx;
        a   <= a - LEN_W'(1);
      end else begin
        pat <= pat | (y << pos[LEN_W-2:0]);
        pos <= pos + ly;
        b   <= b - LEN_W'(1);
      end
    end
    if (cmd.rotate && do_rot) begin
      pat <= ((pat >> rot_r[LEN_W-2:0]) | (pat << back[LEN_W-2:0])) & mask;
    end
    if (cmd.out_load) begin
      pattern  <= pat;
      length   <= tl ? '0 : steps_r[LEN_W-1:0];
      too_long <= tl;
    end
  end

endmodule

FILE: sv/erg_ctrl.sv
// Controller: sequences load, merge, flatten and rotate, and owns the output valid.
module erg_ctrl import erg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        if (status.trivial) begin
          state_next = S_DONE;
        end else if (status.merge_done) begin
          state_next = S_FLAT;
        end else begin
          cmd.merge = 1'b1;
        end
      end
      S_FLAT: begin
        if (status.flat_done) begin
          state_next = S_ROT;
        end else begin
          cmd.flat = 1'b1;
        end
      end
      S_ROT: begin
        cmd.rotate = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free or being drained
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: sv/euclidean_rhythm_generator_unit.sv
// Top level of the euclidean rhythm generator.
// Each input beat (hits, steps, rotation) yields one output beat holding a Bjorklund
// rhythm of up to 64 steps as a bit mask, bit i set when step i is a hit, with its
// length and a too_long flag for steps above 64. An accepted beat is loaded, then
// goes through the merge, flatten and rotate states before the result reaches the output
// register. Here m is the number of group-merge rounds and g is the number of groups left
// after merging (at most hits + 1). The merge and flatten loops handle one round or one
// group per cycle. Every round removes at least one group, so m + g never exceeds steps.
// Empty, full, zero-hit and too-long requests skip merging, flattening and rotation.
// One item is worked on at a time; the next is taken while a finished result still
// waits in the output register.
`include "assert_macros.svh"

module euclidean_rhythm_generator_unit import erg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       hits,
  input  logic [7:0]       steps,
  input  logic [7:0]       rotation,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PAT_W-1:0] pattern,
  output logic [LEN_W-1:0] length,
  output logic             too_long
);

  cmd_t    cmd;
  status_t status;

  erg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  erg_dp u_dp (
    .clk      (clk),
    .hits     (hits),
    .steps    (steps),
    .rotation (rotation),
    .cmd      (cmd),
    .status   (status),
    .pattern  (pattern),
    .length   (length),
    .too_long (too_long)
  );

  `ERG_ASSERT(a_busy_after_accept, clk, rst, (in_valid && !in_stall) |=> in_stall, "accepted a beat but not busy next cycle")
  `ERG_ASSERT(a_out_load_free, clk, rst, cmd.out_load |-> (!out_valid || !out_stall), "result loaded over a stalled output beat")
  `ERG_ASSERT(a_cmd_onehot, clk, rst, $onehot0(cmd), "more than one datapath command at once")
  `ERG_ASSERT(a_too_long_zero, clk, rst, (out_valid && too_long) |-> (pattern == '0 && length == '0), "too-long result not zero")

endmodule

FILE: test/tb_euclidean_rhythm_generator_unit.sv
// Self-checking testbench for the euclidean rhythm generator unit.
module tb_euclidean_rhythm_generator_unit import erg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 300;
  localparam int TAIL_WAIT  = 100;

  typedef struct packed {
    logic [7:0] hits;
    logic [7:0] steps;
    logic [7:0] rotation;
  } rhythm_req_t;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] length;
    logic             too_long;
  } rhythm_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       hits = '0;
  logic [7:0]       steps = '0;
  logic [7:0]       rotation = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PAT_W-1:0] pattern;
  logic [LEN_W-1:0] length;
  logic             too_long;

  rhythm_req_t pending_requests[$];
  rhythm_t     expected_rhythms[$];
  rhythm_req_t next_req;
  rhythm_t     want;

  int n_queued = 0;
  int n_accepted = 0;
  int n_mismatches = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  euclidean_rhythm_generator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .hits      (hits),
    .steps     (steps),
    .rotation  (rotation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pattern   (pattern),
    .length    (length),
    .too_long  (too_long)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Bjorklund: merge remainder groups onto front groups, flatten, then rotate left.
  function automatic rhythm_t euclid_rhythm(rhythm_req_t req);
    logic [PAT_W-1:0] grp [MAX_STEPS];
    int unsigned      grp_len [MAX_STEPS];
    int unsigned      n, k, cnt, split, moves, pos;
    logic [PAT_W-1:0] mask, pat;
    rhythm_t          res;
    n = req.steps;
    k = req.hits;
    res = '0;
    if (n == 0) return res;
    if (n > MAX_STEPS) begin
      res.too_long = 1'b1;
      return res;
    end
    mask = (n >= PAT_W) ? '1 : (PAT_W'(1) << n) - 1;
    pat = '0;
    if (k >= n) begin
      pat = mask;
    end else if (k != 0) begin
      for (int i = 0; i < n; i++) begin
        grp[i] = (i < k) ? PAT_W'(1) : '0;
        grp_len[i] = 1;
      end
      cnt = n;
      split = k;
      while (split < cnt && cnt - split > 1) begin
        moves = (split < cnt - split) ? split : cnt - split;
        for (int i = 0; i < moves; i++) begin
          grp[i] = grp[i] | (grp[split + i] << grp_len[i]);
          grp_len[i] += grp_len[split + i];
        end
        for (int i = split + moves; i < cnt; i++) begin
          grp[i - moves] = grp[i];
          grp_len[i - moves] = grp_len[i];
        end
        cnt -= moves;
        split = moves;
      end
      pos = 0;
      for (int i = 0; i < cnt; i++) begin
        if (pos < PAT_W) pat = pat | (grp[i] << pos);
        pos += grp_len[i];
      end
      pat = pat & mask;
      if (req.rotation != 0 && req.rotation < n)
        pat = ((pat >> req.rotation) | (pat << (n - req.rotation))) & mask;
    end
    res.pattern = pat;
    res.length = LEN_W'(n);
    return res;
  endfunction

  task automatic add_request(input int h, input int s, input int r);
    rhythm_req_t req;
    req.hits = 8'(h);
    req.steps = 8'(s);
    req.rotation = 8'(r);
    pending_requests.insert(pending_requests.size(), req);
    n_queued++;
  endtask

  // Mostly in-range lengths with hits up to steps; the rest is raw noise.
  task automatic add_random(input int count);
    int sel, s, h, r;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 80) begin
        s = $urandom_range(MAX_STEPS, 1);
        h = $urandom_range(s, 0);
        r = $urandom_range(1) ? $urandom_range(s - 1, 0) : $urandom_range(255);
      end else if (sel < 90) begin
        s = $urandom_range(MAX_STEPS, 0);
        h = $urandom_range(255);
        r = $urandom_range(255);
      end else begin
        s = $urandom_range(255);
        h = $urandom_range(255);
        r = $urandom_range(255);
      end
      add_request(h, s, r);
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (n_accepted != n_queued || expected_rhythms.size() != 0);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count, input bit hold);
    int base;
    sender_idle_pct = idle;
    stall_pct = stall;
    base = n_accepted;
    add_random(count);
    if (hold) begin
      do @(negedge clk);
      while (n_accepted < base + 20);
      hold_asked++;
    end
    drain();
  endtask

  task automatic report_mismatch(input string what, input logic [PAT_W-1:0] exp_val,
                                 input logic [PAT_W-1:0] act_val);
    n_mismatches++;
    if (n_mismatches <= 10)
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, exp_val, act_val);
  endtask

  // Driver: hold a stalled beat, advance to the next pending request after acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_rhythms.insert(expected_rhythms.size(),
                                euclid_rhythm('{hits, steps, rotation}));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_req = pending_requests.pop_front();
          hits <= next_req.hits;
          steps <= next_req.steps;
          rotation <= next_req.rotation;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a requested hold-off keeps stall high until its HOLD_LEN counter runs out.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      hold_given <= hold_given + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_rhythms.size() == 0) begin
        report_mismatch("unexpected beat", '0, pattern);
      end else begin
        want = expected_rhythms.pop_front();
        if (pattern !== want.pattern) report_mismatch("pattern", want.pattern, pattern);
        if (length !== want.length) report_mismatch("length", want.length, length);
        if (too_long !== want.too_long) report_mismatch("too_long", want.too_long, too_long);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL euclidean_rhythm_generator_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // empty, too long, full, zero hits, rotation edges, classic rhythms
    add_request(0, 0, 0);
    add_request(255, 255, 255);
    add_request(3, 65, 1);
    add_request(5, 0, 3);
    add_request(10, 4, 2);
    add_request(8, 8, 0);
    add_request(0, 16, 5);
    add_request(3, 8, 0);
    add_request(3, 8, 1);
    add_request(3, 8, 7);
    add_request(3, 8, 8);
    add_request(5, 8, 200);
    add_request(7, 16, 3);
    add_request(1, 64, 63);
    add_request(63, 64, 1);
    add_request(32, 64, 17);
    add_request(13, 64, 0);
    add_request(1, 1, 0);
    add_request(0, 1, 0);
    add_request(1, 2, 1);
    add_request(2, 5, 4);
    add_request(64, 64, 0);
    add_request(7, 12, 5);
    add_request(170, 85, 85);
    add_request(85, 170, 170);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    drain();
    run_phase(0, 0, 190, 1'b1);
    run_phase(69, 0, 185, 1'b0);
    run_phase(0, 69, 185, 1'b0);
    run_phase(22, 22, 185, 1'b0);
    repeat (TAIL_WAIT) @(negedge clk);
    n_mismatches += expected_rhythms.size();
    if (n_mismatches == 0) begin
      $display("PASS euclidean_rhythm_generator_unit");
    end else begin
      $display("FAIL euclidean_rhythm_generator_unit");
    end
    $finish;
  end

endmodule
